### design/chd_pkg.sv
`default_nettype none

package chd_pkg;

    // Number of CORDIC micro-rotations, one pipeline stage each.
    localparam int CORDIC_STEPS = 24;

    // Samples are scaled up by this many bits before the rotations start.
    localparam int PRESCALE_BITS = 30;

    // Binary angle width: 2^32 is one full turn.
    localparam int ANGLE_W = 32;

    // Half a turn as a binary angle.
    localparam logic [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) as a binary angle, rounded.
    localparam logic [ANGLE_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    // Flags that ride along with each sample for the axis special case.
    typedef struct packed {
        logic y_zero;
        logic x_neg;
    } t_side;

endpackage

`default_nettype wire

### design/chd_cordic_stage.sv
`default_nettype none

// One registered CORDIC vectoring micro-rotation.
module chd_cordic_stage #(
    parameter int XY_W = 48,
    parameter int STEP = 0
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire chd_pkg::t_side                     i_side,
    input  wire logic signed [XY_W-1:0]             i_x,
    input  wire logic signed [XY_W-1:0]             i_y,
    input  wire logic [chd_pkg::ANGLE_W-1:0]        i_z,
    output logic                                    o_valid,
    output chd_pkg::t_side                          o_side,
    output logic signed [XY_W-1:0]                  o_x,
    output logic signed [XY_W-1:0]                  o_y,
    output logic [chd_pkg::ANGLE_W-1:0]             o_z
);

    logic                              r_valid;
    chd_pkg::t_side                    r_side;
    logic signed [XY_W-1:0]            r_x;
    logic signed [XY_W-1:0]            r_y;
    logic [chd_pkg::ANGLE_W-1:0]       r_z;

    logic signed [XY_W-1:0]            n_x;
    logic signed [XY_W-1:0]            n_y;
    logic [chd_pkg::ANGLE_W-1:0]       n_z;
    logic signed [XY_W-1:0]            dx;
    logic signed [XY_W-1:0]            dy;

    always_comb begin
        dx = i_y >>> STEP;
        dy = i_x >>> STEP;
        // Rotate toward the x axis; the sign of y picks the direction.
        if (i_y > 0) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + chd_pkg::ATAN_TAB[STEP];
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - chd_pkg::ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side <= i_side;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

`default_nettype wire

### design/compass_heading_top.sv
`default_nettype none

// Channel     Direction  Signals                          Transfer
// ---------   ---------  -------------------------------  ---------------------------------
// sample      in         start, busy, i_mag_x, i_mag_y    edge with start high, busy low
// heading     out        o_done, o_heading                every edge with o_done high
// config      in         i_cfg_we, i_cfg_wdata            every edge with i_cfg_we high
//
// A new sample pair may be transferred on every clock; busy is always low.
// Each heading appears on o_heading for one cycle with o_done high, after
// its sample passes one prescale stage, 24 CORDIC stages, one multiply stage,
// one rounding stage and one declination and wrap stage.
// The synchronous active-low reset clears the valid bits and the declination.
// The receiver cannot stall, so the pipeline never holds and nothing is lost.
module compass_heading_top #(
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_mag_x,
    input  wire logic signed [SAMPLE_WIDTH-1:0] i_mag_y,
    input  wire logic                           i_cfg_we,
    input  wire logic signed [15:0]             i_cfg_wdata,
    output logic                                o_done,
    output logic [15:0]                         o_heading
);

    // Prescaled samples grow by the CORDIC gain and one sign bit.
    localparam int XY_W   = SAMPLE_WIDTH + chd_pkg::PRESCALE_BITS + 2;
    localparam int NSTG   = chd_pkg::CORDIC_STEPS;
    localparam int AW     = chd_pkg::ANGLE_W;
    localparam int FULL   = 360 << ANGLE_FRAC_BITS;
    localparam int HALF   = 180 << ANGLE_FRAC_BITS;
    localparam int FULL_W = $clog2(FULL + 1);
    localparam int PROD_W = AW + FULL_W;
    localparam int SUM_W  = ((FULL_W > 16) ? FULL_W : 16) + 2;

    localparam logic [PROD_W-1:0]       ROUND_HALF = PROD_W'(64'h8000_0000);
    localparam logic signed [SUM_W-1:0] FULL_S     = SUM_W'(FULL);

    // Declination register.
    logic signed [15:0]        r_declination;

    // Prescale stage.
    logic                      r_s0_valid;
    chd_pkg::t_side            r_s0_side;
    logic signed [XY_W-1:0]    r_s0_x;
    logic signed [XY_W-1:0]    r_s0_y;
    logic [AW-1:0]             r_s0_z;
    logic signed [XY_W-1:0]    n_s0_x;
    logic signed [XY_W-1:0]    n_s0_y;
    logic [AW-1:0]             n_s0_z;
    logic signed [XY_W-1:0]    px;
    logic signed [XY_W-1:0]    py;

    // CORDIC chain taps.
    logic                      c_valid [NSTG+1];
    chd_pkg::t_side            c_side  [NSTG+1];
    logic signed [XY_W-1:0]    c_x     [NSTG+1];
    logic signed [XY_W-1:0]    c_y     [NSTG+1];
    logic [AW-1:0]             c_z     [NSTG+1];

    // Multiply, rounding and wrap stages.
    logic                      r_m_valid;
    chd_pkg::t_side            r_m_side;
    logic [PROD_W-1:0]         r_m_prod;
    logic                      r_r_valid;
    logic [FULL_W-1:0]         r_r_base;
    logic [FULL_W-1:0]         n_r_base;
    logic [PROD_W-1:0]         rounded;
    logic                      r_done;
    logic [15:0]               r_heading;
    logic signed [SUM_W-1:0]   sum;
    logic signed [SUM_W-1:0]   n_heading;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_declination <= '0;
        end else if (i_cfg_we) begin
            r_declination <= i_cfg_wdata;
        end
    end

    // Scale both axes up, then fold the left half plane onto the right one
    // by a half-turn rotation so the CORDIC only has to cover +-90 degrees.
    always_comb begin
        px = XY_W'(i_mag_x) <<< chd_pkg::PRESCALE_BITS;
        py = XY_W'(i_mag_y) <<< chd_pkg::PRESCALE_BITS;
        if (i_mag_x < 0) begin
            n_s0_x = -px;
            n_s0_y = -py;
            n_s0_z = chd_pkg::HALF_TURN;
        end else begin
            n_s0_x = px;
            n_s0_y = py;
            n_s0_z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else begin
            r_s0_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_side.y_zero <= (i_mag_y == '0);
        r_s0_side.x_neg  <= (i_mag_x < 0);
        r_s0_x           <= n_s0_x;
        r_s0_y           <= n_s0_y;
        r_s0_z           <= n_s0_z;
    end

    assign c_valid[0] = r_s0_valid;
    assign c_side[0]  = r_s0_side;
    assign c_x[0]     = r_s0_x;
    assign c_y[0]     = r_s0_y;
    assign c_z[0]     = r_s0_z;

    // One micro-rotation per stage; the angle accumulates modulo a full turn.
    for (genvar g = 0; g < NSTG; g++) begin : g_cordic
        chd_cordic_stage #(
            .XY_W (XY_W),
            .STEP (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (c_valid[g]),
            .i_side  (c_side[g]),
            .i_x     (c_x[g]),
            .i_y     (c_y[g]),
            .i_z     (c_z[g]),
            .o_valid (c_valid[g+1]),
            .o_side  (c_side[g+1]),
            .o_x     (c_x[g+1]),
            .o_y     (c_y[g+1]),
            .o_z     (c_z[g+1])
        );
    end

    // Scale the binary angle to degree units: angle times a full circle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= c_valid[NSTG];
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_side <= c_side[NSTG];
        r_m_prod <= PROD_W'(c_z[NSTG]) * PROD_W'(FULL);
    end

    // Round half up and drop the 32 fraction bits. A sample on the x axis
    // bypasses the CORDIC result: 180 degrees for negative x, else 0.
    always_comb begin
        rounded = r_m_prod + ROUND_HALF;
        if (r_m_side.y_zero) begin
            n_r_base = r_m_side.x_neg ? FULL_W'(HALF) : '0;
        end else begin
            n_r_base = rounded[PROD_W-1:AW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
        end else begin
            r_r_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r_base <= n_r_base;
    end

    // Add the declination and wrap once. Exactly 360 degrees is kept.
    always_comb begin
        sum = SUM_W'(r_r_base) + SUM_W'(r_declination);
        if (sum < 0) begin
            n_heading = sum + FULL_S;
        end else if (sum > FULL_S) begin
            n_heading = sum - FULL_S;
        end else begin
            n_heading = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_heading <= n_heading[15:0];
    end

    assign o_done    = r_done;
    assign o_heading = r_heading;

endmodule

`default_nettype wire
